// ----- sv/bpt_pkg.sv -----
// ---------------------------------------------------------------------------
// bpt_pkg
// Shared widths, limits and sequencer codes for the bit-plane transpose.
// ---------------------------------------------------------------------------
package bpt_pkg;

  localparam int WORD_W           = 32;
  localparam int PLANE_W          = 5;   // selects one of 32 bit planes
  localparam int CNT_W            = 7;   // holds a length up to RESULT_LIMIT
  localparam int J_W              = 6;   // element index below RESULT_LIMIT
  localparam int REM_W            = 6;   // remainder below PAD_MULTIPLE
  localparam int RESULT_LIMIT     = 64;
  localparam int DEF_MAX_WORDS    = 64;
  localparam int DEF_PAD_MULTIPLE = 8;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

endpackage

// ----- sv/bit_plane_transpose.sv -----
// ---------------------------------------------------------------------------
// bit_plane_transpose
// Loads a vector of 32-bit words and emits it in bit-plane order.
// ---------------------------------------------------------------------------
// Words are taken one per cycle while busy is low. The word marked in_last
// closes the vector: its length L is padded with zero words up to a
// multiple of PAD_MULTIPLE (no padding if that would pass 64 words),
// giving P. The block then gathers the output stream one bit per cycle
// through the single read port of the element store. After the last word
// is taken, busy stays high through the gather and the registered read
// of the final bit. The final result word is shown in the first cycle
// with busy low. Each result word is shown for exactly one cycle with
// out_valid; the receiver cannot stall it and must take it when it appears.
// ---------------------------------------------------------------------------
module bit_plane_transpose #(
  parameter int MAX_WORDS    = bpt_pkg::DEF_MAX_WORDS,
  parameter int PAD_MULTIPLE = bpt_pkg::DEF_PAD_MULTIPLE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bpt_pkg::WORD_W-1:0] in_word,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic [bpt_pkg::WORD_W-1:0] out_word,
  output logic                       out_last
);

  import bpt_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [WORD_W-1:0] mem [MAX_WORDS];

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic [J_W-1:0]    j_r, j_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;

  // read stage
  logic              bit_vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic [PLANE_W-1:0] sel_r;
  logic              inr_r;
  logic              fin_r;

  // collect stage
  logic [WORD_W-1:0]  acc_r;
  logic [WORD_W-1:0]  acc_nxt;
  logic [PLANE_W-1:0] o_r;
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_word_r;
  logic               out_last_r;

  logic              accept;
  logic              store_en;
  logic [CNT_W-1:0]  len_new;
  logic [REM_W-1:0]  rem_new;
  logic [CNT_W:0]    padded_w;
  logic [CNT_W-1:0]  p_last;
  logic              j_wrap;
  logic              fin_bit;
  logic              issue;
  logic              cur_bit;

  assign busy     = (state_r == ST_EMIT) || bit_vld_r;
  assign accept   = start && !busy;
  assign store_en = accept && (count_r < CNT_W'(MAX_WORDS));
  assign issue    = (state_r == ST_EMIT);

  assign len_new = store_en ? count_r + CNT_W'(1) : count_r;
  assign rem_new = !store_en ? rem_r :
                   (rem_r == REM_W'(PAD_MULTIPLE - 1)) ? '0 : rem_r + REM_W'(1);

  // round up to the pad multiple unless that passes the result limit
  assign padded_w = (rem_new == '0) ? {1'b0, len_new} :
                    {1'b0, len_new} + (CNT_W+1)'(PAD_MULTIPLE) - (CNT_W+1)'(rem_new);

  assign p_last  = p_r - CNT_W'(1);
  assign j_wrap  = ({1'b0, j_r} == p_last);
  assign fin_bit = j_wrap && (plane_r == '1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    plane_nxt = plane_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          count_nxt = len_new;
          rem_nxt   = rem_new;
          if (in_last) begin
            len_nxt   = len_new;
            p_nxt     = (padded_w > (CNT_W+1)'(RESULT_LIMIT)) ? len_new
                                                             : padded_w[CNT_W-1:0];
            count_nxt = '0;
            rem_nxt   = '0;
            j_nxt     = '0;
            plane_nxt = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (j_wrap) begin
          j_nxt     = '0;
          plane_nxt = plane_r + PLANE_W'(1);
        end else begin
          j_nxt = j_r + J_W'(1);
        end
        if (fin_bit) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      rem_r   <= '0;
      len_r   <= '0;
      p_r     <= '0;
      j_r     <= '0;
      plane_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      len_r   <= len_nxt;
      p_r     <= p_nxt;
      j_r     <= j_nxt;
      plane_r <= plane_nxt;
    end
  end

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[count_r[AW-1:0]] <= in_word;
    end
    rd_data_r <= mem[j_r[AW-1:0]];
    sel_r     <= ~plane_r;
    inr_r     <= ({1'b0, j_r} < len_r);
    fin_r     <= fin_bit;
  end

  // padding words and entries past the loaded length read as zero
  assign cur_bit = inr_r && rd_data_r[sel_r];
  assign acc_nxt = {acc_r[WORD_W-2:0], cur_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_vld_r   <= 1'b0;
      o_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bit_vld_r   <= issue;
      out_valid_r <= bit_vld_r && (o_r == '1);
      if (bit_vld_r) begin
        o_r <= o_r + PLANE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bit_vld_r) begin
      acc_r <= acc_nxt;
      if (o_r == '1) begin
        out_word_r <= acc_nxt;
        out_last_r <= fin_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_valid_r && out_last_r;

  // a word only completes out of bits gathered while busy
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result word without gathering");

  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ({1'b0, j_r} < p_r))
    else $error("element index past padded length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WORDS))
    else $error("element count past store depth");

  // the final bit of a vector closes a word
  a_fin_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_vld_r && fin_r) |-> (o_r == '1))
    else $error("vector ends inside a word");

  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |=> (count_r == '0))
    else $error("element loaded during emission");

endmodule

// ----- tb/sv/bit_plane_transpose_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bit_plane_transpose_test
// Drives vectors of 32-bit words into the bit-plane transpose and checks
// every transposed word and its last flag against a local model of the
// store, the zero padding and the plane gather.
// ---------------------------------------------------------------------------
module bit_plane_transpose_test;
  import bpt_pkg::*;

  localparam int HELD_MAX   = DEF_MAX_WORDS;
  localparam int PAD_MULT   = DEF_PAD_MULTIPLE;
  localparam int TAIL_WAIT  = 80;    // idle margin to catch stray result words
  localparam int QUIET_ROWS = 40;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } plane_word_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
    bit                fixed;
    logic [WORD_W-1:0] fix_word;
    int                fix_count;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [WORD_W-1:0] in_word;
  logic              in_last;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_last;

  stim_row_t         stim_rows[$];
  plane_word_t       pending_planes[$];
  logic [WORD_W-1:0] held_words[HELD_MAX];
  int                held_count = 0;
  int                mismatches = 0;

  bit_plane_transpose u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_last  (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic add_row(input logic [WORD_W-1:0] word, input logic last,
                         input bit fixed = 1'b0, input logic [WORD_W-1:0] fix_word = '0,
                         input int fix_count = 0);
    stim_row_t r;
    r.word      = word;
    r.last      = last;
    r.fixed     = fixed;
    r.fix_word  = fix_word;
    r.fix_count = fix_count;
    stim_rows.push_back(r);
  endtask

  // store the word; on a last word, pad and gather the bit planes, or queue the fixed words of a directed row
  task automatic take_word(input stim_row_t r);
    int                len;
    int                padded;
    int                k;
    int                plane;
    int                j;
    logic [WORD_W-1:0] acc;
    plane_word_t       pw;
    if (held_count < HELD_MAX) begin
      held_words[held_count] = r.word;
      held_count++;
    end
    if (r.last) begin
      if (r.fixed) begin
        for (int i = 0; i < r.fix_count; i++) begin
          pw.word = r.fix_word;
          pw.last = (i == r.fix_count - 1);
          pending_planes.push_back(pw);
        end
      end else begin
        len    = held_count;
        padded = len;
        if (len % PAD_MULT != 0) padded = len + PAD_MULT - len % PAD_MULT;
        if (padded > RESULT_LIMIT) padded = len;
        for (int w = 0; w < padded; w++) begin
          acc = '0;
          for (int o = 0; o < WORD_W; o++) begin
            k     = w * WORD_W + o;
            plane = k / padded;
            j     = k % padded;
            if (j < len) acc[WORD_W-1-o] = held_words[j][WORD_W-1-plane];
          end
          pw.word = acc;
          pw.last = (w == padded - 1);
          pending_planes.push_back(pw);
        end
      end
      held_count = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input plane_word_t exp_w,
                               input plane_word_t got_w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected word %h last %b, got word %h last %b",
               what, exp_w.word, exp_w.last, got_w.word, got_w.last);
    end
  endtask

  always @(posedge clk) begin
    plane_word_t got_w;
    plane_word_t exp_w;
    got_w.word = out_word;
    got_w.last = out_last;
    if (rst_n && out_valid) begin
      if (pending_planes.size() == 0) begin
        exp_w = '0;
        note_mismatch("no word expected", exp_w, got_w);
      end else begin
        exp_w = pending_planes.pop_front();
        if (got_w.word !== exp_w.word || got_w.last !== exp_w.last) begin
          note_mismatch("wrong word", exp_w, got_w);
        end
      end
    end
  end

  initial begin
    int        idx;
    int        gap;
    int        len;
    int        sel;
    int        rand_items;
    int        directed_end;
    int        quiet_from;
    stim_row_t r;

    // directed: single zero, single all-ones, full group of ones, mixed 9 words
    add_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 8);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8080_8080, 8);
    for (int i = 0; i < 8; i++) begin
      add_row(32'hFFFF_FFFF, i == 7, 1'b1, 32'hFFFF_FFFF, 8);
    end
    add_row(32'h8000_0000, 1'b0);
    add_row(32'h0000_0001, 1'b0);
    add_row(32'h7FFF_FFFF, 1'b0);
    add_row(32'hFFFF_FFFE, 1'b0);
    add_row(32'hA5A5_A5A5, 1'b0);
    add_row(32'h5A5A_5A5A, 1'b0);
    add_row(32'h1234_5678, 1'b0);
    add_row(32'h0000_0000, 1'b0);
    add_row(32'hDEAD_BEEF, 1'b1);
    directed_end = stim_rows.size();

    // random vectors: a full store first, then one that overflows it, then random lengths
    rand_items = 0;
    while (rand_items < 400) begin
      if (rand_items == 0) begin
        len = HELD_MAX;
      end else if (rand_items == HELD_MAX) begin
        len = HELD_MAX + 6;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 60)      len = $urandom_range(1, 12);
        else if (sel < 85) len = $urandom_range(13, 40);
        else if (sel < 95) len = $urandom_range(41, HELD_MAX);
        else               len = $urandom_range(HELD_MAX + 1, HELD_MAX + 8);
      end
      for (int i = 0; i < len; i++) begin
        sel = $urandom_range(0, 15);
        if (sel == 0)      add_row('0, i == len - 1);
        else if (sel == 1) add_row('1, i == len - 1);
        else               add_row($urandom, i == len - 1);
      end
      rand_items += len;
    end
    quiet_from = stim_rows.size() - QUIET_ROWS;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;
    in_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < stim_rows.size()) begin
      if (idx == directed_end || (idx < quiet_from && $urandom_range(0, 39) == 0)) begin
        if (pending_planes.size() != 0) begin
          start <= 1'b0;
          while (pending_planes.size() != 0) @(posedge clk);
        end
      end else if (idx < quiet_from && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        start   <= 1'b0;
        in_word <= $urandom;
        in_last <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
      r = stim_rows[idx];
      start   <= 1'b1;
      in_word <= r.word;
      in_last <= r.last;
      // hold the word until the block takes it
      @(posedge clk);
      while (busy) @(posedge clk);
      take_word(r);
      idx++;
    end
    start   <= 1'b0;
    in_word <= '0;
    in_last <= 1'b0;

    while (pending_planes.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0 && pending_planes.size() == 0) begin
      $display("bit_plane_transpose verification clean");
    end else begin
      $display("bit_plane_transpose verification failed");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("bit_plane_transpose verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bpt_pkg.sv
sv/bit_plane_transpose.sv
tb/sv/bit_plane_transpose_test.sv
